// ----- sv/isw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isw_pkg;

  // Bus geometry
  localparam int unsigned RAM_BYTES = 8192;
  localparam int unsigned ADDR_W    = 13;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned INDEX_W   = 7;
  localparam int unsigned SHIFT_W   = 3;

  // Address map
  localparam logic [ADDR_W-1:0] WIN_MASK     = 13'h1FF8;
  localparam logic [ADDR_W-1:0] WIN_BASE     = 13'h1FF0;
  localparam logic [ADDR_W-1:0] BANK_HI      = 13'h1800;
  localparam logic [ADDR_W-1:0] BANK_LO      = 13'h1C00;
  localparam logic [ADDR_W-1:0] FIELD_OFFSET = 13'h0200;

  // Window offsets
  localparam logic [2:0] OFF_FIELD = 3'd4;
  localparam logic [2:0] OFF_BANK  = 3'd5;
  localparam logic [2:0] OFF_INDEX = 3'd6;

  // Access kind on the bus
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Reset values of the window registers
  localparam logic               BANK_RESET  = 1'b1;
  localparam logic [INDEX_W-1:0] INDEX_RESET = 7'h7F;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd6;
  localparam logic [DATA_W-1:0]  FILL_BYTE   = 8'hFF;

  // What the decoder asks the controller to do
  typedef enum logic [2:0] {
    ACT_READ,
    ACT_WRITE,
    ACT_FIELD,
    ACT_BANK,
    ACT_INDEX
  } isw_act_e;

  typedef struct packed {
    isw_act_e          act;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] field_addr;
  } isw_dec_t;

endpackage

`default_nettype wire

// ----- sv/isw_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface isw_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [isw_pkg::ADDR_W-1:0]       address;
  logic [isw_pkg::DATA_W-1:0]       write_data;

  modport source (output valid, kind, address, write_data, input ready);
  modport sink   (input valid, kind, address, write_data, output ready);
endinterface

`default_nettype wire

// ----- sv/isw_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface isw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [isw_pkg::DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ----- sv/isw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Single-port byte RAM, registered read data
module isw_ram #(
  parameter int unsigned RAM_BYTES = isw_pkg::RAM_BYTES,
  localparam int unsigned AW       = $clog2(RAM_BYTES)
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic                       re_i,
  input  wire logic [AW-1:0]              addr_i,
  input  wire logic [isw_pkg::DATA_W-1:0] wdata_i,
  output logic      [isw_pkg::DATA_W-1:0] rdata_o
);

  logic [isw_pkg::DATA_W-1:0] mem [RAM_BYTES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/isw_dec.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Window decode: maps a bus word to an action and a RAM address
module isw_dec (
  input  wire logic                        kind_i,
  input  wire logic [isw_pkg::ADDR_W-1:0]  address_i,
  input  wire logic                        bank_i,
  input  wire logic [isw_pkg::INDEX_W-1:0] index_i,
  output isw_pkg::isw_dec_t                dec_o
);

  logic                       win;
  logic [2:0]                 off;
  logic [isw_pkg::ADDR_W-1:0] base;
  logic [isw_pkg::ADDR_W-1:0] entry_addr;
  logic [isw_pkg::ADDR_W-1:0] field_addr;

  assign win  = (address_i & isw_pkg::WIN_MASK) == isw_pkg::WIN_BASE;
  assign off  = address_i[2:0];
  assign base = bank_i ? isw_pkg::BANK_HI : isw_pkg::BANK_LO;

  // entry byte: base + index*4 + offset
  assign entry_addr = base
                    + isw_pkg::ADDR_W'({index_i, 2'b00})
                    + isw_pkg::ADDR_W'(off[1:0]);

  // packed 2-bit field byte: base + index/4 + 0x200
  assign field_addr = base
                    + isw_pkg::ADDR_W'(index_i[isw_pkg::INDEX_W-1:2])
                    + isw_pkg::FIELD_OFFSET;

  always_comb begin
    dec_o.act        = (kind_i == isw_pkg::KIND_WRITE) ? isw_pkg::ACT_WRITE
                                                       : isw_pkg::ACT_READ;
    dec_o.addr       = address_i;
    dec_o.field_addr = field_addr;
    if (win) begin
      if (off[2] == 1'b0) begin
        dec_o.addr = entry_addr;
      end else if (off == isw_pkg::OFF_FIELD) begin
        dec_o.addr = field_addr;
        if (kind_i == isw_pkg::KIND_WRITE) begin
          dec_o.act = isw_pkg::ACT_FIELD;
        end
      end else if (kind_i == isw_pkg::KIND_WRITE) begin
        // bank and index writes also store the byte in place
        if (off == isw_pkg::OFF_BANK) begin
          dec_o.act = isw_pkg::ACT_BANK;
        end else if (off == isw_pkg::OFF_INDEX) begin
          dec_o.act = isw_pkg::ACT_INDEX;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/indirect_sprite_table_window_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                          Word
// req_i    in   kind, address, write_data       one bus access
// rsp_o    out  read_data                       one byte per read access
//
// Reads and packed-field writes go on to S_RDATA or S_MERGE, other writes
// finish when taken; the single RAM port and its registered read set this.
// After reset a clearing pass fills all RAM_BYTES (8192) bytes with 0xFF,
// with req_i.ready low throughout.
// The result sits in an output register; a new access is taken while it
// waits only if it is taken in the same cycle.
module indirect_sprite_table_window_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  isw_req_if.sink    req_i,
  isw_rsp_if.source  rsp_o
);

  localparam int unsigned RAM_BYTES = isw_pkg::RAM_BYTES;
  localparam int unsigned AW        = $clog2(RAM_BYTES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_MERGE
  } state_e;

  state_e                      state_q, state_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic                        bank_q, bank_d;
  logic [isw_pkg::INDEX_W-1:0] index_q, index_d;
  logic [isw_pkg::SHIFT_W-1:0] shift_q, shift_d;
  logic [1:0]                  fd_q, fd_d;
  logic                        out_valid_q, out_valid_d;
  logic [isw_pkg::DATA_W-1:0]  out_data_q, out_data_d;

  logic                        accept;
  isw_pkg::isw_dec_t           dec;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_addr;
  logic [isw_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;
  logic [isw_pkg::DATA_W-1:0]  fmask, fbits;

  isw_dec u_dec (
    .kind_i    (req_i.kind),
    .address_i (req_i.address),
    .bank_i    (bank_q),
    .index_i   (index_q),
    .dec_o     (dec)
  );

  isw_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // handshake
  assign req_i.ready     = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept          = req_i.valid && req_i.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

  // two-bit field merge
  assign fmask = isw_pkg::DATA_W'(8'd3 << shift_q);
  assign fbits = isw_pkg::DATA_W'({6'd0, fd_q} << shift_q) & fmask;

  // sequencer and RAM port control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bank_d      = bank_q;
    index_d     = index_q;
    shift_d     = shift_q;
    fd_d        = fd_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = AW'(dec.addr);
    ram_wdata   = req_i.write_data;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = isw_pkg::FILL_BYTE;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(RAM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (dec.act)
            isw_pkg::ACT_READ: begin
              ram_re  = 1'b1;
              state_d = S_RDATA;
            end
            isw_pkg::ACT_FIELD: begin
              ram_re  = 1'b1;
              fd_d    = req_i.write_data[1:0];
              state_d = S_MERGE;
            end
            isw_pkg::ACT_BANK: begin
              ram_we = 1'b1;
              bank_d = req_i.write_data[0];
            end
            isw_pkg::ACT_INDEX: begin
              ram_we  = 1'b1;
              index_d = req_i.write_data[isw_pkg::INDEX_W-1:0];
              shift_d = {req_i.write_data[1:0], 1'b0};
            end
            default: begin
              ram_we = 1'b1;
            end
          endcase
        end
      end
      S_RDATA: begin
        out_valid_d = 1'b1;
        out_data_d  = ram_rdata;
        state_d     = S_IDLE;
      end
      S_MERGE: begin
        // bank and index cannot change in between, so the address is recomputed
        ram_we    = 1'b1;
        ram_addr  = AW'(dec.field_addr);
        ram_wdata = (ram_rdata & ~fmask) | fbits;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      bank_q      <= isw_pkg::BANK_RESET;
      index_q     <= isw_pkg::INDEX_RESET;
      shift_q     <= isw_pkg::SHIFT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bank_q      <= bank_d;
      index_q     <= index_d;
      shift_q     <= shift_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fd_q       <= fd_d;
    out_data_q <= out_data_d;
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("access taken during clearing pass");

  a_out_free_on_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDATA) |-> !out_valid_q)
    else $error("read data would overwrite a pending result");

  a_read_to_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == isw_pkg::KIND_READ) |=> (state_q == S_RDATA))
    else $error("read access did not issue a RAM read");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RDATA))
    else $error("result raised without a read");

  a_shift_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (shift_q[0] == 1'b0))
    else $error("field shift not on a 2-bit boundary");

endmodule

`default_nettype wire
